// File: rtl/slm_pkg.sv
// ----------------------------------------------------------------------------
// slm_pkg
// Shared widths, mode codes and the command beat type of the sorted list merger.
// ----------------------------------------------------------------------------
package slm_pkg;

    localparam int DATA_W         = 32;
    localparam int MODE_W         = 2;
    localparam int LIST_DEPTH_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;

    // input mode codes
    localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GO     = 2'd2;

    // classified command kinds held in the queue
    typedef enum logic [1:0] {
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_GO
    } cmd_kind_t;

    // head of the command queue as seen by the back end
    typedef struct packed {
        logic              valid;
        cmd_kind_t         kind;
        logic [DATA_W-1:0] value;
    } cmd_t;

endpackage

// File: rtl/slm_ram.sv
// ----------------------------------------------------------------------------
// slm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module slm_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/slm_front.sv
// ----------------------------------------------------------------------------
// slm_front
// Accepts input beats, classifies the mode and queues commands for the back end.
// ----------------------------------------------------------------------------
module slm_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [slm_pkg::MODE_W-1:0]  mode,
    input  logic [slm_pkg::DATA_W-1:0]  value,
    input  logic                        pop,
    output logic                        busy,
    output slm_pkg::cmd_t               head
);
    import slm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_kind_t         q_kind_reg  [QUEUE_DEPTH];
    logic [DATA_W-1:0] q_value_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    cmd_kind_t kind;
    logic      keep;
    logic      push;
    logic      do_pop;

    // mode decode, unused code is dropped here
    always_comb
    begin
        kind = CMD_GO;
        keep = 1'b0;
        unique case (mode)
            MODE_LOAD_A:
            begin
                kind = CMD_LOAD_A;
                keep = 1'b1;
            end
            MODE_LOAD_B:
            begin
                kind = CMD_LOAD_B;
                keep = 1'b1;
            end
            MODE_GO:
            begin
                kind = CMD_GO;
                keep = 1'b1;
            end
            default:
            begin
                kind = CMD_GO;
                keep = 1'b0;
            end
        endcase
    end

    assign busy   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push   = start && !busy && keep;
    assign do_pop = pop && (count_reg != '0);

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_kind_reg[wr_ptr_reg]  <= kind;
            q_value_reg[wr_ptr_reg] <= value;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.kind  = q_kind_reg[rd_ptr_reg];
    assign head.value = q_value_reg[rd_ptr_reg];

endmodule

// File: rtl/slm_back.sv
// ----------------------------------------------------------------------------
// slm_back
// Executes queued commands: appends to the list stores and runs the merge.
// ----------------------------------------------------------------------------
module slm_back #(
    parameter int LIST_DEPTH = slm_pkg::LIST_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  slm_pkg::cmd_t                     head,
    output logic                              pop,
    output logic                              strobe,
    output logic signed [slm_pkg::DATA_W-1:0] merged_value,
    output logic                              last,
    output logic                              overflowed
);
    import slm_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_MERGE = 1'b1;

    logic          state_reg, state_next;
    logic [CW-1:0] count_a_reg, count_a_next;
    logic [CW-1:0] count_b_reg, count_b_next;
    logic [CW-1:0] ia_reg, ia_next;
    logic [CW-1:0] ib_reg, ib_next;
    logic          ovf_reg, ovf_next;

    logic                     strobe_reg, strobe_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic                     last_reg, last_next;
    logic                     ovf_out_reg, ovf_out_next;

    logic              we_a, we_b;
    logic [AW-1:0]     raddr_a, raddr_b;
    logic [DATA_W-1:0] rdata_a, rdata_b;

    logic          a_left, b_left, take_a, is_last;
    logic          full_a, full_b;
    logic [CW:0]   total;
    logic [CW:0]   emitted;
    logic [CW-1:0] ia_inc, ib_inc;

    // list stores
    slm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (count_a_reg[AW-1:0]),
        .wdata (head.value),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    slm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (count_b_reg[AW-1:0]),
        .wdata (head.value),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    // head compare, list b wins ties
    assign a_left  = (ia_reg < count_a_reg);
    assign b_left  = (ib_reg < count_b_reg);
    assign take_a  = (a_left && b_left) ? ($signed(rdata_a) < $signed(rdata_b)) : a_left;
    assign ia_inc  = ia_reg + 1'b1;
    assign ib_inc  = ib_reg + 1'b1;
    assign total   = {1'b0, count_a_reg} + {1'b0, count_b_reg};
    assign emitted = {1'b0, ia_reg} + {1'b0, ib_reg};
    assign is_last = ((emitted + 1'b1) == total);
    assign full_a  = (count_a_reg == CW'(LIST_DEPTH));
    assign full_b  = (count_b_reg == CW'(LIST_DEPTH));

    // read addresses run one step ahead so a head is ready every cycle
    always_comb
    begin
        raddr_a = '0;
        raddr_b = '0;
        if (state_reg == ST_MERGE)
        begin
            raddr_a = take_a ? ia_inc[AW-1:0] : ia_reg[AW-1:0];
            raddr_b = take_a ? ib_reg[AW-1:0] : ib_inc[AW-1:0];
        end
    end

    assign pop  = (state_reg == ST_IDLE) && head.valid;
    assign we_a = pop && (head.kind == CMD_LOAD_A) && !full_a;
    assign we_b = pop && (head.kind == CMD_LOAD_B) && !full_b;

    // command sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        ia_next      = ia_reg;
        ib_next      = ib_reg;
        ovf_next     = ovf_reg;
        strobe_next  = 1'b0;
        value_next   = value_reg;
        last_next    = last_reg;
        ovf_out_next = ovf_out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    case (head.kind)
                        CMD_LOAD_A:
                        begin
                            if (full_a)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                count_a_next = count_a_reg + 1'b1;
                            end
                        end
                        CMD_LOAD_B:
                        begin
                            if (full_b)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                count_b_next = count_b_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            ia_next = '0;
                            ib_next = '0;
                            if (total == '0)
                            begin
                                ovf_next = 1'b0;
                            end
                            else
                            begin
                                state_next = ST_MERGE;
                            end
                        end
                    endcase
                end
            end
            ST_MERGE:
            begin
                strobe_next  = 1'b1;
                value_next   = take_a ? $signed(rdata_a) : $signed(rdata_b);
                last_next    = is_last;
                ovf_out_next = ovf_reg;
                if (take_a)
                begin
                    ia_next = ia_inc;
                end
                else
                begin
                    ib_next = ib_inc;
                end
                if (is_last)
                begin
                    count_a_next = '0;
                    count_b_next = '0;
                    ovf_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_a_reg <= '0;
            count_b_reg <= '0;
            ia_reg      <= '0;
            ib_reg      <= '0;
            ovf_reg     <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
            ia_reg      <= ia_next;
            ib_reg      <= ib_next;
            ovf_reg     <= ovf_next;
            strobe_reg  <= strobe_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        last_reg    <= last_next;
        ovf_out_reg <= ovf_out_next;
    end

    assign strobe       = strobe_reg;
    assign merged_value = value_reg;
    assign last         = last_reg;
    assign overflowed   = ovf_out_reg;

endmodule

// File: rtl/sorted_list_merger.sv
// ----------------------------------------------------------------------------
// sorted_list_merger
// Two-way merge of two ascending lists of signed 32-bit values.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken on a rising edge with start high and busy low.
//   mode 0 appends value to list A, mode 1 to list B, mode 2 merges and emits,
//   mode 3 is dropped. Appends beyond LIST_DEPTH entries per list are lost and
//   set the overflow bit that is reported on every result of the next merge.
//   Each result beat is on merged_value, last and overflowed for one cycle
//   with strobe high; the receiver cannot stall, results are never held back.
//   Timing: commands pass a two-entry queue. An append occupies the back end
//   only for its pop, so appends sustain one per cycle while no merge runs.
//   A merge of N stored values occupies the back end for its pop and then
//   one result per cycle, set by the single read port of each list store;
//   with the back end idle a merge beat passes the queue and is popped into
//   the merge state, which fills the result registers. busy is high while the
//   queue is full. After a merge both lists and the overflow bit are empty again.
//   Reset clears the counts, the queue and the overflow bit; no clearing pass
//   runs over the stores.
// ----------------------------------------------------------------------------
module sorted_list_merger #(
    parameter int LIST_DEPTH = slm_pkg::LIST_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [slm_pkg::MODE_W-1:0]        mode,
    input  logic signed [slm_pkg::DATA_W-1:0] value,
    output logic                              busy,
    output logic                              strobe,
    output logic signed [slm_pkg::DATA_W-1:0] merged_value,
    output logic                              last,
    output logic                              overflowed
);
    import slm_pkg::*;

    cmd_t head;
    logic pop;

    // intake and command queue
    slm_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .value (value),
        .pop   (pop),
        .busy  (busy),
        .head  (head)
    );

    // list stores and merge sequencer
    slm_back #(.LIST_DEPTH(LIST_DEPTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .strobe       (strobe),
        .merged_value (merged_value),
        .last         (last),
        .overflowed   (overflowed)
    );

    // a merge ends with a gap before the next one can emit
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("result beat right after the last beat of a merge");

    // a merge emits one beat per cycle with a constant overflow bit
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe && (overflowed == $past(overflowed)))
        else $error("merge stalled or overflow bit changed within a merge");

    // the queue only fills through an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("queue became full without an accepted beat");

    // the back end never pops while it is merging
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> !pop)
        else $error("command taken from the queue during a merge");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted list merger.
// ----------------------------------------------------------------------------
// A short directed sequence covers extreme values, ties between the list
// heads, an empty merge, unsorted lists and the unused mode. Random list sets
// follow: mostly sorted lists of small sizes, with a few full or overfilled
// lists, unsorted sets and dropped-mode noise mixed in. A scoreboard predicts
// every merged beat from the accepted command beats and checks the result
// beats in order. Command gaps are random, with stretches of back-to-back
// beats.
// ----------------------------------------------------------------------------
module tb_top;

    import slm_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 12;
    localparam int DEPTH          = LIST_DEPTH_DEF;
    localparam int ITEM_TARGET    = 250;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 20;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // one predicted result beat
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     ovf;
    } merge_beat_t;

    // list contents, drop flag and predicted merge output
    class merge_scoreboard;
        int                       depth;
        logic signed [DATA_W-1:0] list_a[$];
        logic signed [DATA_W-1:0] list_b[$];
        bit                       drop_seen;
        merge_beat_t              merged_q[$];
        int                       errors;
        int                       loads;
        int                       merges;
        int                       drops;
        int                       checked;

        function new(int list_depth);
            depth     = list_depth;
            drop_seen = 0;
            errors    = 0;
            loads     = 0;
            merges    = 0;
            drops     = 0;
            checked   = 0;
        endfunction

        // update list state for one accepted command beat
        function void note_beat(logic [MODE_W-1:0] m, logic signed [DATA_W-1:0] v);
            int          ia;
            int          ib;
            int          total;
            bit          take_a;
            merge_beat_t beat;
            case (m)
                MODE_LOAD_A:
                begin
                    loads++;
                    if (list_a.size() < depth)
                        list_a.push_back(v);
                    else
                    begin
                        drop_seen = 1;
                        drops++;
                    end
                end
                MODE_LOAD_B:
                begin
                    loads++;
                    if (list_b.size() < depth)
                        list_b.push_back(v);
                    else
                    begin
                        drop_seen = 1;
                        drops++;
                    end
                end
                MODE_GO:
                begin
                    merges++;
                    ia    = 0;
                    ib    = 0;
                    total = list_a.size() + list_b.size();
                    for (int k = 0; k < total; k++)
                    begin
                        // strict less-than: equal heads give list b first
                        if (ia < list_a.size() && ib < list_b.size())
                            take_a = list_a[ia] < list_b[ib];
                        else
                            take_a = ia < list_a.size();
                        if (take_a)
                        begin
                            beat.value = list_a[ia];
                            ia++;
                        end
                        else
                        begin
                            beat.value = list_b[ib];
                            ib++;
                        end
                        beat.last = (k + 1 == total);
                        beat.ovf  = drop_seen;
                        merged_q.push_back(beat);
                    end
                    list_a.delete();
                    list_b.delete();
                    drop_seen = 0;
                end
                default:
                begin
                    // unused mode leaves everything alone
                end
            endcase
        endfunction

        // compare one result beat with the oldest prediction
        function void check_result(logic signed [DATA_W-1:0] v, logic l, logic o);
            merge_beat_t exp_beat;
            checked++;
            if (merged_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat value=%0d last=%b overflowed=%b",
                         $time, v, l, o);
                return;
            end
            exp_beat = merged_q.pop_front();
            if (v !== exp_beat.value)
            begin
                errors++;
                $display("%0t: merged_value expected %0d actual %0d",
                         $time, exp_beat.value, v);
            end
            if (l !== exp_beat.last)
            begin
                errors++;
                $display("%0t: last expected %b actual %b", $time, exp_beat.last, l);
            end
            if (o !== exp_beat.ovf)
            begin
                errors++;
                $display("%0t: overflowed expected %b actual %b", $time, exp_beat.ovf, o);
            end
        endfunction

        function int pending();
            return merged_q.size();
        endfunction
    endclass

    logic                     clk   = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [MODE_W-1:0]        mode  = MODE_LOAD_A;
    logic signed [DATA_W-1:0] value = '0;
    logic                     busy;
    logic                     strobe;
    logic signed [DATA_W-1:0] merged_value;
    logic                     last;
    logic                     overflowed;

    merge_scoreboard sb;
    bit              burst_on   = 0;
    int              item_count = 0;
    int              idle_count = 0;

    sorted_list_merger #(
        .LIST_DEPTH(DEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .mode        (mode),
        .value       (value),
        .busy        (busy),
        .strobe      (strobe),
        .merged_value(merged_value),
        .last        (last),
        .overflowed  (overflowed)
    );

    // clock
    always #CLK_HALF clk = ~clk;

    // monitor: accepted command beats and result beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe === 1'b1)
                sb.check_result(merged_value, last, overflowed);
            if (start && busy === 1'b0)
                sb.note_beat(mode, value);
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && busy === 1'b0) || strobe === 1'b1)
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (idle_count >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d beats still expected",
                         $time, sb.pending());
                $display("sorted_list_merger verification failed");
                $finish;
            end
        end
    end

    // gap before a command beat: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // drive one command beat and wait until it is taken
    task automatic send_beat(input logic [MODE_W-1:0] m, input logic signed [DATA_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        mode  <= m;
        value <= v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (m != MODE_UNUSED)
            item_count++;
    endtask

    function automatic logic signed [DATA_W-1:0] rand_element(bit narrow);
        if (narrow)
            return $signed(DATA_W'($urandom_range(0, 15))) - 8;
        return $urandom;
    endfunction

    // one list set: loads to both lists in random order, then a merge
    task automatic run_list_set(input int na, input int nb, input bit sorted, input bit narrow);
        logic signed [DATA_W-1:0] qa[$];
        logic signed [DATA_W-1:0] qb[$];
        bit                       pick_a;
        for (int i = 0; i < na; i++)
            qa.push_back(rand_element(narrow));
        for (int i = 0; i < nb; i++)
            qb.push_back(rand_element(narrow));
        if (sorted)
        begin
            qa.sort();
            qb.sort();
        end
        while (qa.size() > 0 || qb.size() > 0)
        begin
            if ($urandom_range(0, 19) == 0)
                send_beat(MODE_UNUSED, $urandom);
            if (qa.size() == 0)
                pick_a = 0;
            else if (qb.size() == 0)
                pick_a = 1;
            else
                pick_a = $urandom_range(0, 1);
            if (pick_a)
                send_beat(MODE_LOAD_A, qa.pop_front());
            else
                send_beat(MODE_LOAD_B, qb.pop_front());
        end
        send_beat(MODE_GO, $urandom);
    endtask

    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(0, 6);
        if (r < 93)
            return $urandom_range(7, 16);
        return $urandom_range(DEPTH - 2, DEPTH + 3);
    endfunction

    // main sequence
    initial
    begin
        int na;
        int nb;
        sb = new(DEPTH);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: extremes with ties between the list heads
        send_beat(MODE_LOAD_A, 32'sh8000_0000);
        send_beat(MODE_LOAD_A, -1);
        send_beat(MODE_LOAD_A, 0);
        send_beat(MODE_LOAD_A, 32'sh7fff_ffff);
        send_beat(MODE_LOAD_B, 32'sh8000_0000);
        send_beat(MODE_LOAD_B, 0);
        send_beat(MODE_LOAD_B, 5);
        send_beat(MODE_LOAD_B, 32'sh7fff_ffff);
        send_beat(MODE_UNUSED, 32'sh5555_5555);
        send_beat(MODE_GO, 0);
        // directed: empty merge
        send_beat(MODE_GO, 32'shffff_ffff);
        // directed: unsorted lists
        send_beat(MODE_LOAD_A, 5);
        send_beat(MODE_LOAD_A, 3);
        send_beat(MODE_LOAD_B, 4);
        send_beat(MODE_GO, 0);
        // directed: single element in one list, with bit patterns
        send_beat(MODE_LOAD_B, 32'sh5555_5555);
        send_beat(MODE_GO, 32'shaaaa_aaaa);
        send_beat(MODE_LOAD_A, 32'shaaaa_aaaa);
        send_beat(MODE_GO, 0);

        // random list sets
        while (item_count < ITEM_TARGET)
        begin
            burst_on = ($urandom_range(0, 3) == 0);
            na = pick_size();
            nb = pick_size();
            run_list_set(na, nb, $urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0);
        end
        // both lists overfilled: the longest merge
        run_list_set(DEPTH + 1, DEPTH + 2, 1, 0);

        start <= 1'b0;
        // let the monitor note the final merge beat before draining
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d loads, %0d merges, %0d dropped appends",
                 sb.loads, sb.merges, sb.drops);
        $display("%0d result beats checked, %0d errors", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("sorted_list_merger verification clean");
        else
            $display("sorted_list_merger verification failed");
        $finish;
    end

endmodule

// File: files.f
rtl/slm_pkg.sv
rtl/slm_ram.sv
rtl/slm_front.sv
rtl/slm_back.sv
rtl/sorted_list_merger.sv
bench/tb_top.sv
